>>> rtl/itaf_pkg.sv
// Shared types, codes and character helpers for the integer to ASCII formatter.
package itaf_pkg;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  mode;
    } item_t;

    typedef struct packed {
        logic [6:0] ascii_char;
        logic       last;
    } result_t;

    localparam logic [1:0] MODE_DEC = 2'd0;
    localparam logic [1:0] MODE_HEX = 2'd1;
    localparam logic [1:0] MODE_BIN = 2'd2;

    localparam logic [2:0] SEL_ZERO  = 3'd0;
    localparam logic [2:0] SEL_X     = 3'd1;
    localparam logic [2:0] SEL_B     = 3'd2;
    localparam logic [2:0] SEL_SPACE = 3'd3;
    localparam logic [2:0] SEL_DIGIT = 3'd4;
    localparam logic [2:0] SEL_BIT   = 3'd5;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_ONE   = 7'h31;
    localparam logic [6:0] CHAR_X     = 7'h78;
    localparam logic [6:0] CHAR_B     = 7'h62;
    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_A     = 7'h41;

    typedef struct packed {
        logic       load;
        logic       dec;
        logic       conv;
        logic       shift_digit;
        logic       shift_bit;
        logic       emit;
        logic [2:0] sel;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic cnt_one;
        logic bit_last;
    } status_t;

    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + {3'b000, d};
        end
        else
        begin
            c = CHAR_A + {3'b000, d - 4'd10};
        end
        return c;
    endfunction

endpackage

>>> rtl/itaf_ctrl.sv
// Sequencer for the formatter: conversion, prefix, leading-zero strip and emission.
module itaf_ctrl
    import itaf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic [1:0] mode,
    input  status_t status,
    output logic    busy,
    output cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_PFX0  = 3'd2;
    localparam logic [2:0] ST_PFX1  = 3'd3;
    localparam logic [2:0] ST_SKIP  = 3'd4;
    localparam logic [2:0] ST_DIGIT = 3'd5;
    localparam logic [2:0] ST_SPACE = 3'd6;
    localparam logic [2:0] ST_BIT   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] fmt_reg;
    logic [1:0] fmt_next;
    logic [1:0] fmt_in;

    // unused mode code formats as decimal
    assign fmt_in = (mode == MODE_HEX || mode == MODE_BIN) ? mode : MODE_DEC;
    assign busy   = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        fmt_next        = fmt_reg;
        cmd             = '0;
        cmd.dec         = (fmt_reg == MODE_DEC);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    fmt_next = fmt_in;
                    cmd.load = 1'b1;
                    cmd.dec  = (fmt_in == MODE_DEC);
                    state_next = (fmt_in == MODE_DEC) ? ST_CONV : ST_PFX0;
                end
            end
            ST_CONV:
            begin
                cmd.conv = 1'b1;
                if (status.conv_done)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_PFX0:
            begin
                cmd.emit   = 1'b1;
                cmd.sel    = SEL_ZERO;
                state_next = ST_PFX1;
            end
            ST_PFX1:
            begin
                cmd.emit   = 1'b1;
                cmd.sel    = (fmt_reg == MODE_HEX) ? SEL_X : SEL_B;
                state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                // drop leading zero digits, keep at least one
                if (status.top_zero && !status.cnt_one)
                begin
                    cmd.shift_digit = 1'b1;
                end
                else
                begin
                    // a zero value in binary prints a single digit, no grouping
                    state_next = (fmt_reg == MODE_BIN && !status.top_zero) ?
                                 ST_SPACE : ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                cmd.emit        = 1'b1;
                cmd.sel         = SEL_DIGIT;
                cmd.last        = status.cnt_one;
                cmd.shift_digit = 1'b1;
                if (status.cnt_one)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SPACE:
            begin
                cmd.emit   = 1'b1;
                cmd.sel    = SEL_SPACE;
                state_next = ST_BIT;
            end
            ST_BIT:
            begin
                cmd.emit      = 1'b1;
                cmd.sel       = SEL_BIT;
                cmd.last      = status.cnt_one && status.bit_last;
                cmd.shift_bit = 1'b1;
                if (status.bit_last)
                begin
                    state_next = status.cnt_one ? ST_IDLE : ST_SPACE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fmt_reg   <= MODE_DEC;
        end
        else
        begin
            state_reg <= state_next;
            fmt_reg   <= fmt_next;
        end
    end

endmodule

>>> rtl/itaf_datapath.sv
// Datapath: value shift register, bit-serial BCD converter, digit counters, output register.
module itaf_datapath
    import itaf_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] value,
    input  cmd_t        cmd,
    output status_t     status,
    output logic        strobe,
    output result_t     result
);

    localparam int IW     = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int NW     = (VALUE_WIDTH + 3) / 4;
    localparam int WP     = NW * 4;
    localparam int ND     = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BW     = ND * 4;
    localparam int CONV_W = $clog2(WP);
    localparam int CNT_W  = $clog2(ND + 1);

    logic [WP-1:0]     bin_reg;
    logic [WP-1:0]     bin_next;
    logic [BW-1:0]     bcd_reg;
    logic [BW-1:0]     bcd_next;
    logic [CONV_W-1:0] conv_cnt_reg;
    logic [CONV_W-1:0] conv_cnt_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [1:0]        bit_cnt_reg;
    logic [1:0]        bit_cnt_next;
    logic              strobe_reg;
    result_t           result_reg;
    result_t           result_next;
    logic [BW-1:0]     bcd_adj;
    logic [3:0]        top_digit;

    assign top_digit = cmd.dec ? bcd_reg[BW-1 -: 4] : bin_reg[WP-1 -: 4];

    assign status.conv_done = (conv_cnt_reg == CONV_W'(WP - 1));
    assign status.top_zero  = (top_digit == 4'd0);
    assign status.cnt_one   = (cnt_reg == CNT_W'(1));
    assign status.bit_last  = (bit_cnt_reg == 2'd3);

    // add 3 to every BCD digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < ND; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ?
                                bcd_reg[i*4 +: 4] + 4'd3 : bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        bin_next      = bin_reg;
        bcd_next      = bcd_reg;
        conv_cnt_next = conv_cnt_reg;
        cnt_next      = cnt_reg;
        bit_cnt_next  = bit_cnt_reg;
        if (cmd.load)
        begin
            bin_next      = WP'(value[IW-1:0]);
            bcd_next      = '0;
            conv_cnt_next = '0;
            cnt_next      = cmd.dec ? CNT_W'(ND) : CNT_W'(NW);
            bit_cnt_next  = '0;
        end
        else if (cmd.conv)
        begin
            {bcd_next, bin_next} = {bcd_adj[BW-2:0], bin_reg, 1'b0};
            conv_cnt_next        = conv_cnt_reg + CONV_W'(1);
        end
        else if (cmd.shift_digit)
        begin
            bin_next = bin_reg << 4;
            bcd_next = bcd_reg << 4;
            cnt_next = cnt_reg - CNT_W'(1);
        end
        else if (cmd.shift_bit)
        begin
            bin_next     = bin_reg << 1;
            bit_cnt_next = bit_cnt_reg + 2'd1;
            if (bit_cnt_reg == 2'd3)
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        result_next.last = cmd.last;
        case (cmd.sel)
            SEL_ZERO:  result_next.ascii_char = CHAR_ZERO;
            SEL_X:     result_next.ascii_char = CHAR_X;
            SEL_B:     result_next.ascii_char = CHAR_B;
            SEL_SPACE: result_next.ascii_char = CHAR_SPACE;
            SEL_DIGIT: result_next.ascii_char = digit_char(top_digit);
            SEL_BIT:   result_next.ascii_char = bin_reg[WP-1] ? CHAR_ONE : CHAR_ZERO;
            default:   result_next.ascii_char = CHAR_ZERO;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_cnt_reg <= '0;
            cnt_reg      <= '0;
            bit_cnt_reg  <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            conv_cnt_reg <= conv_cnt_next;
            cnt_reg      <= cnt_next;
            bit_cnt_reg  <= bit_cnt_next;
            strobe_reg   <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

>>> rtl/integer_to_ascii_formatter_top.sv
// Top level of the integer to ASCII formatter.
//
// Input: a word (value, mode) is taken at a rising edge where start is high
// and busy is low. busy stays high until the last character has been issued.
// Output: one character per strobe cycle, most significant first, with
// result.last set on the final one. The receiver cannot stall the block;
// every strobe cycle carries a character that is taken at that cycle's end.
// Decimal: the value runs through a bit-serial BCD converter, one bit a
// cycle, then leading zero digits are stripped one digit a cycle (up to 9),
// then one digit a cycle is issued. Hex and binary: the prefix 0x or 0b
// is issued, up to 7 leading zero nibbles are stripped, then one character
// a cycle is issued (binary: a space plus four bits per nibble, or a single
// 0 for a zero value). A character is on the port the cycle after it is
// issued. A new word can be taken in the cycle the last character is on
// the port. Reset clears the sequencer and the strobe; no clearing pass is
// needed.
module integer_to_ascii_formatter_top
    import itaf_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    strobe,
    output result_t result
);

    cmd_t    cmd;
    status_t status;

    itaf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (item.mode),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    itaf_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .value  (item.value),
        .cmd    (cmd),
        .status (status),
        .strobe (strobe),
        .result (result)
    );

endmodule

>>> rtl/itaf_checker.sv
// Port-level checker for the formatter, bound to the top level.
module itaf_checker
    import itaf_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    strobe,
    input result_t result
);

    // an accepted word must hold the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // only the final character may appear while idle
    a_mid_char_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> busy)
        else $error("non-final character while idle");

    // texts never run together
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last |=> !strobe)
        else $error("character right after last");

    // no character in the first busy cycle
    a_no_char_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> !strobe)
        else $error("character in first busy cycle");

endmodule

bind integer_to_ascii_formatter_top itaf_checker u_itaf_checker (.*);

>>> tb/sv/integer_to_ascii_formatter_top_test.sv
// Self-checking testbench for the integer to ASCII formatter: directed table plus random words.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_top_test;
    import itaf_pkg::*;

    // Mode 3 has no name in the package; the block formats it as decimal.
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int DIRECTED_ROWS = 23;
    localparam int RANDOM_WORDS = 160;
    localparam int DRAIN_CYCLES = 64;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    strobe;
    result_t result;

    result_t    pending_chars[$];
    logic [6:0] text_q[$];
    result_t    head_char;
    int         errors;
    int         chars_checked;
    int         words_sent;
    int         mode_hits[4];
    bit         quiet;

    // Rows with text typed in are checked as written; empty rows go to the predictor.
    item_t dir_item [DIRECTED_ROWS] = '{
        {32'h0000_0000, MODE_DEC},
        {32'h0000_0000, MODE_HEX},
        {32'h0000_0000, MODE_BIN},
        {32'h0000_0000, MODE_SPARE},
        {32'hFFFF_FFFF, MODE_DEC},
        {32'hFFFF_FFFF, MODE_HEX},
        {32'hFFFF_FFFF, MODE_BIN},
        {32'hFFFF_FFFF, MODE_SPARE},
        {32'h0000_0001, MODE_DEC},
        {32'h0000_0001, MODE_HEX},
        {32'h0000_0001, MODE_BIN},
        {32'h0000_0009, MODE_DEC},
        {32'h0000_000A, MODE_DEC},
        {32'h0000_000F, MODE_HEX},
        {32'h0000_0010, MODE_HEX},
        {32'h0000_0010, MODE_BIN},
        {32'h8000_0000, MODE_DEC},
        {32'h8000_0000, MODE_BIN},
        {32'h3B9A_CA00, MODE_DEC},
        {32'h3B9A_C9FF, MODE_DEC},
        {32'h00AB_CDEF, MODE_HEX},
        {32'h1234_5678, MODE_BIN},
        {32'h5A5A_5A5A, MODE_SPARE}
    };

    string dir_text [DIRECTED_ROWS] = '{
        "0",
        "0x0",
        "0b0",
        "0",
        "4294967295",
        "0xFFFFFFFF",
        "0b 1111 1111 1111 1111 1111 1111 1111 1111",
        "4294967295",
        "1",
        "0x1",
        "0b 0001",
        "9",
        "10",
        "0xF",
        "0x10",
        "0b 0001 0000",
        "2147483648",
        "",
        "1000000000",
        "",
        "",
        "",
        ""
    };

    integer_to_ascii_formatter_top dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Fill text_q with the characters the word should produce.
    function automatic void format_text(item_t it);
        logic [31:0] v;
        logic [3:0]  nib;
        int          top;
        int          k;
        int          b;
        v = it.value;
        top = 0;
        text_q.delete();
        for (k = 0; k < 8; k++)
        begin
            if (v[4 * k +: 4] != 4'h0)
            begin
                top = k;
            end
        end
        case (it.mode)
            MODE_HEX:
            begin
                text_q.push_back(CHAR_ZERO);
                text_q.push_back(CHAR_X);
                for (k = top; k >= 0; k--)
                begin
                    nib = v[4 * k +: 4];
                    if (nib < 4'd10)
                    begin
                        text_q.push_back(CHAR_ZERO + 7'(nib));
                    end
                    else
                    begin
                        text_q.push_back(CHAR_A + 7'(nib) - 7'd10);
                    end
                end
            end
            MODE_BIN:
            begin
                text_q.push_back(CHAR_ZERO);
                text_q.push_back(CHAR_B);
                if (v == 32'd0)
                begin
                    text_q.push_back(CHAR_ZERO);
                end
                else
                begin
                    // Every nibble group, the leading one too, gets a space in front.
                    for (k = top; k >= 0; k--)
                    begin
                        text_q.push_back(CHAR_SPACE);
                        for (b = 3; b >= 0; b--)
                        begin
                            text_q.push_back(v[4 * k + b] ? CHAR_ONE : CHAR_ZERO);
                        end
                    end
                end
            end
            default:
            begin
                do
                begin
                    text_q.push_front(CHAR_ZERO + 7'(v % 32'd10));
                    v = v / 32'd10;
                end
                while (v != 32'd0);
            end
        endcase
    endfunction

    function automatic void queue_text();
        result_t r;
        int      i;
        for (i = 0; i < text_q.size(); i++)
        begin
            r.ascii_char = text_q[i];
            r.last = (i == text_q.size() - 1);
            pending_chars.push_back(r);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 80);
    endfunction

    // Hold start high until the word is taken; start stays high across back-to-back words.
    task automatic send_word(item_t it, int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        queue_text();
        words_sent++;
        mode_hits[it.mode]++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected character: ascii_char %h last %b",
                       result.ascii_char, result.last);
                errors++;
            end
            else
            begin
                head_char = pending_chars.pop_front();
                if (result.ascii_char !== head_char.ascii_char)
                begin
                    $error("ascii_char: expected %h actual %h",
                           head_char.ascii_char, result.ascii_char);
                    errors++;
                end
                if (result.last !== head_char.last)
                begin
                    $error("last: expected %b actual %b", head_char.last, result.last);
                    errors++;
                end
                chars_checked++;
            end
        end
    end

    initial
    begin
        item_t it;
        int    i;
        int    n;
        errors = 0;
        chars_checked = 0;
        words_sent = 0;
        quiet = 1'b0;
        for (i = 0; i < 4; i++)
        begin
            mode_hits[i] = 0;
        end
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (dir_text[i].len() == 0)
            begin
                format_text(dir_item[i]);
            end
            else
            begin
                text_q.delete();
                for (n = 0; n < dir_text[i].len(); n++)
                begin
                    text_q.push_back(7'(dir_text[i][n]));
                end
            end
            send_word(dir_item[i], pick_gap());
        end

        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            // Drop idling entirely for some stretches of 30 words.
            if (n % 30 == 0)
            begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            case ($urandom_range(0, 9))
                0: it.value = $urandom_range(0, 15);
                1: it.value = 32'hFFFF_FFFF >> $urandom_range(0, 31);
                2: it.value = 32'h1 << $urandom_range(0, 31);
                3, 4: it.value = $urandom;
                default: it.value = $urandom >> $urandom_range(0, 31);
            endcase
            i = $urandom_range(0, 15);
            if (i < 5)
            begin
                it.mode = MODE_DEC;
            end
            else if (i < 10)
            begin
                it.mode = MODE_HEX;
            end
            else if (i < 15)
            begin
                it.mode = MODE_BIN;
            end
            else
            begin
                it.mode = MODE_SPARE;
            end
            format_text(it);
            send_word(it, pick_gap());
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d words (dec %0d, hex %0d, bin %0d, mode 3 %0d), %0d chars checked",
                 words_sent, mode_hits[MODE_DEC], mode_hits[MODE_HEX],
                 mode_hits[MODE_BIN], mode_hits[MODE_SPARE], chars_checked);
        if (errors == 0)
        begin
            $display("integer_to_ascii_formatter_top regression: pass");
        end
        else
        begin
            $display("integer_to_ascii_formatter_top regression: fail");
        end
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("timeout with %0d characters outstanding", pending_chars.size());
        $display("integer_to_ascii_formatter_top regression: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/itaf_pkg.sv
rtl/itaf_ctrl.sv
rtl/itaf_datapath.sv
rtl/integer_to_ascii_formatter_top.sv
rtl/itaf_checker.sv
tb/sv/integer_to_ascii_formatter_top_test.sv
